FILE: src/ptb_pkg.sv
package ptb_pkg;

    localparam int TIMER_SLOTS = 8;
    localparam int SLOT_W      = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;

    localparam int TICK_W    = 32;
    localparam int RATE_W    = 20;
    localparam int PERIOD_W  = 32;
    localparam int PROD_W    = PERIOD_W + RATE_W;

    // 1000000 = 15625 << 6: shift out the 64, then multiply by ceil(2^60 / 15625)
    localparam int SCALE_SH = 6;
    localparam int QIN_W    = PROD_W - SCALE_SH;
    localparam int RECIP_W  = 47;
    localparam int RECIP_SH = 60;
    localparam logic [RECIP_W-1:0] RECIP = 47'd73786976294839;
    localparam int HALF_W   = QIN_W / 2;
    localparam int MHI_W    = RECIP_W - HALF_W;
    localparam int PP_W     = HALF_W + MHI_W;
    localparam int ACC_W    = QIN_W + RECIP_W;

    localparam int DIV_STEPS = 4;
    localparam int CNT_W     = 2;

    localparam int US_PER_S = 1000000;

    localparam logic [RATE_W-1:0] RATE_RESET = RATE_W'(1000);

    localparam int PADDR_W = 3;
    localparam logic REG_TICK_RATE = 1'b0;

    localparam logic [1:0] FN_ADD  = 2'd0;
    localparam logic [1:0] FN_DEL  = 2'd1;
    localparam logic [1:0] FN_TICK = 2'd2;

    localparam logic [1:0] STS_OK   = 2'd0;
    localparam logic [1:0] STS_FULL = 2'd1;
    localparam logic [1:0] STS_ZERO = 2'd2;

    typedef struct packed {
        logic              add_en;
        logic              del_en;
        logic              tick_en;
        logic [2:0]        del_slot;
        logic [TICK_W-1:0] ticks;
        logic              one_shot;
    } t_cell_cmd;

endpackage

FILE: src/periodic_timer_bank.sv
// Delete, tick and unused items: result registered at the accepting edge,
// one item a cycle while results are taken.
// Add items: multiply period by tick rate, then partial products of the reciprocal
// multiplication for the divide by 1000000, then the timer is placed.
// One item is in flight at a time; a new item is taken once any add has finished and the result register frees.
// Synchronous active-low reset clears all slots and sets the tick rate to 1000 Hz.
module periodic_timer_bank (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [ptb_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic [1:0]                  i_func,
    input  logic [31:0]                 i_period_us,
    input  logic                        i_one_shot,
    input  logic [2:0]                  i_target_slot,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic [1:0]                  o_status,
    output logic [2:0]                  o_assigned_slot,
    output logic [7:0]                  o_expired_mask
);
    import ptb_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_MUL  = 2'd1;
    localparam logic [1:0] ST_DIV  = 2'd2;
    localparam logic [1:0] ST_DONE = 2'd3;

    logic [1:0]          r_state;
    logic [RATE_W-1:0]   r_rate;
    logic [PERIOD_W-1:0] r_period;
    logic                r_one_shot;
    logic [PROD_W-1:0]   r_dvd;
    logic [ACC_W-1:0]    r_acc;
    logic [CNT_W-1:0]    r_cnt;
    logic                r_out_valid;
    logic [1:0]          r_status;
    logic [2:0]          r_slot;
    logic [7:0]          r_mask;

    logic                      w_accept;
    logic                      w_apply;
    logic                      w_cfg_wr;
    logic [QIN_W-1:0]          w_scaled;
    logic [HALF_W-1:0]         w_mul_a;
    logic [MHI_W-1:0]          w_mul_b;
    logic [PP_W-1:0]           w_prod;
    logic [ACC_W-1:0]          w_pp;
    logic [ACC_W-RECIP_SH-1:0] w_quot;
    logic [TICK_W-1:0]         w_ticks;
    t_cell_cmd                 w_cmd;
    logic [7:0]                w_mask;

    logic [TIMER_SLOTS:0]             w_taken;
    logic [SLOT_W-1:0]                w_slot [TIMER_SLOTS+1];
    logic [TIMER_SLOTS-1:0]           w_exp;

    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_TICK_RATE);
    assign prdata   = (paddr[2] == REG_TICK_RATE) ? 32'(r_rate) : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rate <= RATE_RESET;
        end else if (w_cfg_wr) begin
            r_rate <= pwdata[RATE_W-1:0];
        end
    end

    assign o_in_ready = (r_state == ST_IDLE) && (!r_out_valid || i_out_ready);
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_apply    = (r_state == ST_DONE) && (!r_out_valid || i_out_ready);

    // divide by 1000000: drop the factor 64, then one partial product of the
    // reciprocal of 15625 a cycle
    assign w_scaled = r_dvd[PROD_W-1:SCALE_SH];
    assign w_mul_a  = r_cnt[0] ? w_scaled[QIN_W-1:HALF_W] : w_scaled[HALF_W-1:0];
    assign w_mul_b  = r_cnt[1] ? RECIP[RECIP_W-1:HALF_W] : MHI_W'(RECIP[HALF_W-1:0]);
    assign w_prod   = PP_W'(w_mul_a) * PP_W'(w_mul_b);
    assign w_pp     = (r_cnt[0] && r_cnt[1]) ? (ACC_W'(w_prod) << (2 * HALF_W)) :
                      (r_cnt[0] || r_cnt[1]) ? (ACC_W'(w_prod) << HALF_W) :
                      ACC_W'(w_prod);

    assign w_quot  = r_acc[ACC_W-1:RECIP_SH];
    assign w_ticks = (w_quot[ACC_W-RECIP_SH-1:TICK_W] != '0) ? '1 : w_quot[TICK_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (w_accept && (i_func == FN_ADD)) begin
                        r_state <= ST_MUL;
                    end
                end
                ST_MUL: begin
                    r_state <= ST_DIV;
                end
                ST_DIV: begin
                    if (r_cnt == CNT_W'(DIV_STEPS - 1)) begin
                        r_state <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    if (w_apply) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_period   <= i_period_us;
            r_one_shot <= i_one_shot;
        end
        if (r_state == ST_MUL) begin
            r_dvd <= PROD_W'(r_period) * PROD_W'(r_rate);
            r_acc <= '0;
            r_cnt <= '0;
        end else if (r_state == ST_DIV) begin
            r_acc <= r_acc + w_pp;
            r_cnt <= r_cnt + CNT_W'(1);
        end
    end

    always_comb begin
        w_cmd          = '0;
        w_cmd.add_en   = w_apply && (w_ticks != '0);
        w_cmd.ticks    = w_ticks;
        w_cmd.one_shot = r_one_shot;
        w_cmd.del_en   = w_accept && (i_func == FN_DEL) && (32'(i_target_slot) < TIMER_SLOTS);
        w_cmd.del_slot = i_target_slot;
        w_cmd.tick_en  = w_accept && (i_func == FN_TICK);
    end

    assign w_taken[0] = 1'b0;
    assign w_slot[0]  = '0;

    for (genvar g = 0; g < TIMER_SLOTS; g++) begin : g_cell
        ptb_cell u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_idx     (SLOT_W'(g)),
            .i_cmd     (w_cmd),
            .i_taken   (w_taken[g]),
            .i_slot    (w_slot[g]),
            .o_taken   (w_taken[g+1]),
            .o_slot    (w_slot[g+1]),
            .o_expired (w_exp[g])
        );
    end

    for (genvar b = 0; b < 8; b++) begin : g_mask
        if (b < TIMER_SLOTS) begin : g_on
            assign w_mask[b] = w_exp[b];
        end else begin : g_off
            assign w_mask[b] = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_apply || (w_accept && (i_func != FN_ADD))) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_apply) begin
            r_mask <= '0;
            if (w_ticks == '0) begin
                r_status <= STS_ZERO;
                r_slot   <= '0;
            end else if (w_taken[TIMER_SLOTS]) begin
                r_status <= STS_OK;
                r_slot   <= 3'(w_slot[TIMER_SLOTS]);
            end else begin
                r_status <= STS_FULL;
                r_slot   <= '0;
            end
        end else if (w_accept && (i_func != FN_ADD)) begin
            r_status <= STS_OK;
            r_slot   <= '0;
            r_mask   <= w_mask;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_status        = r_status;
    assign o_assigned_slot = r_slot;
    assign o_expired_mask  = r_mask;

    a_add_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && (i_func == FN_ADD)) |=> (r_state == ST_MUL))
        else $error("add item did not start the conversion");

    a_mask_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_expired_mask != '0)) |-> (o_status == STS_OK))
        else $error("expiry mask with failure status");

    a_div_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_MUL) |=> ((r_state == ST_DIV) && (r_cnt == '0)))
        else $error("divider not restarted");

endmodule

FILE: src/ptb_cell.sv
module ptb_cell (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic [ptb_pkg::SLOT_W-1:0] i_idx,
    input  ptb_pkg::t_cell_cmd         i_cmd,
    input  logic                       i_taken,
    input  logic [ptb_pkg::SLOT_W-1:0] i_slot,
    output logic                       o_taken,
    output logic [ptb_pkg::SLOT_W-1:0] o_slot,
    output logic                       o_expired
);
    import ptb_pkg::*;

    logic              r_active;
    logic              r_one_shot;
    logic [TICK_W-1:0] r_reload;
    logic [TICK_W-1:0] r_remaining;

    logic              w_claim;
    logic              w_del;
    logic              w_dec;
    logic              w_fire;
    logic [TICK_W-1:0] w_left;

    // lowest free slot: first cell in the chain that is free takes the add
    assign w_claim = i_cmd.add_en && !i_taken && !r_active;
    assign w_del   = i_cmd.del_en && (32'(i_cmd.del_slot) == 32'(i_idx));
    assign w_dec   = i_cmd.tick_en && r_active && (r_remaining != '0);
    assign w_left  = r_remaining - TICK_W'(1);
    assign w_fire  = w_dec && (w_left == '0);

    assign o_taken   = i_taken | !r_active;
    assign o_slot    = i_taken ? i_slot : i_idx;
    assign o_expired = w_fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
        end else if (w_claim) begin
            r_active <= 1'b1;
        end else if (w_del) begin
            r_active <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_claim) begin
            r_reload    <= i_cmd.ticks;
            r_remaining <= i_cmd.ticks;
            r_one_shot  <= i_cmd.one_shot;
        end else if (w_dec) begin
            r_remaining <= (w_fire && !r_one_shot) ? r_reload : w_left;
        end
    end

endmodule
